// ----- design/fcba_pkg.sv -----
`default_nettype none

package fcba_pkg;

    // field widths
    localparam int CMD_W = 3;
    localparam int BLK_W = 12;
    localparam int VAL_W = 16;
    localparam int ST_W  = 2;
    localparam int CNT_W = 12;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COUNT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

    // table entry codes
    localparam logic [VAL_W-1:0] ENTRY_FREE = 16'h0000;
    localparam logic [VAL_W-1:0] ENTRY_END  = 16'hFFFF;

    // where the result value comes from
    typedef enum logic [1:0] {
        SRC_ZERO  = 2'd0,
        SRC_PTR   = 2'd1,
        SRC_CNT   = 2'd2,
        SRC_RDATA = 2'd3
    } res_src_t;

    // controller to datapath
    typedef struct packed {
        logic            take_item;
        logic            clr_start;
        logic            clr_step;
        logic            scan_start;
        logic            scan_run;
        logic            scan_count;
        logic            take_hit;
        logic            wr_end;
        logic            wr_link;
        logic            free_start;
        logic            free_read;
        logic            free_write;
        logic            read_issue;
        logic            load_out;
        res_src_t        res_src;
        logic [ST_W-1:0] res_status;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             blk_zero;
        logic             blk_over;
        logic             lim_zero;
        logic             clr_last;
        logic             scan_hit;
        logic             scan_done;
        logic             walk_end;
        logic             walk_bad;
        logic             out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- design/fcba_datapath.sv -----
`default_nettype none

module fcba_datapath #(
    parameter int BLOCK_COUNT = 4096
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire fcba_pkg::ctl_t            ctl,
    output fcba_pkg::sts_t                 sts,
    input  wire logic [fcba_pkg::CMD_W-1:0] in_cmd,
    input  wire logic [fcba_pkg::BLK_W-1:0] in_blk,
    input  wire logic                      cfg_we,
    input  wire logic [fcba_pkg::BLK_W-1:0] cfg_wdata,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [fcba_pkg::VAL_W-1:0]     out_value,
    output logic [fcba_pkg::ST_W-1:0]      out_status
);
    import fcba_pkg::*;

    localparam int ADDR_W  = $clog2(BLOCK_COUNT);
    localparam int LIM_CAP = (BLOCK_COUNT - 1 < 4095) ? BLOCK_COUNT - 1 : 4095;
    localparam int SCAN_W  = BLK_W + 1;

    // table storage
    logic [VAL_W-1:0] mem [BLOCK_COUNT];

    logic [BLK_W-1:0]  lim_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [VAL_W-1:0]  ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SCAN_W-1:0] scan_ptr_reg;
    logic [ADDR_W-1:0] clr_ptr_reg;
    logic              rd_valid_reg;
    logic [BLK_W-1:0]  rd_blk_reg;
    logic [VAL_W-1:0]  rd_data_reg;
    logic              out_valid_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic [ST_W-1:0]   out_status_reg;

    logic              scan_issue;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [VAL_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [VAL_W-1:0]  res_value;

    // scan issues while the pointer is inside the usable range
    assign scan_issue = ctl.scan_run && (scan_ptr_reg <= SCAN_W'(lim_reg));

    // write port select
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = ADDR_W'(ptr_reg);
        mem_wdata = ENTRY_FREE;
        if (ctl.clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = clr_ptr_reg;
        end else if (ctl.wr_end) begin
            mem_we    = 1'b1;
            mem_wdata = ENTRY_END;
        end else if (ctl.wr_link) begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(blk_reg);
            mem_wdata = ptr_reg;
        end else if (ctl.free_write) begin
            mem_we    = 1'b1;
        end
    end

    // read port select
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = ADDR_W'(ptr_reg);
        if (scan_issue) begin
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(scan_ptr_reg);
        end else if (ctl.free_read) begin
            mem_re    = 1'b1;
        end else if (ctl.read_issue) begin
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(blk_reg);
        end
    end

    // memory with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // usable block limit, capped to the highest block index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg <= BLK_W'(LIM_CAP);
        end else if (cfg_we) begin
            lim_reg <= (cfg_wdata > BLK_W'(LIM_CAP)) ? BLK_W'(LIM_CAP) : cfg_wdata;
        end
    end

    // control registers: clearing sweep and scan pipeline flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_ptr_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (ctl.clr_start) begin
                clr_ptr_reg <= '0;
            end else if (ctl.clr_step) begin
                clr_ptr_reg <= clr_ptr_reg + 1'b1;
            end
            rd_valid_reg <= scan_issue;
        end
    end

    // command, pointer and counter registers
    always_ff @(posedge aclk) begin
        rd_blk_reg <= scan_ptr_reg[BLK_W-1:0];
        if (ctl.take_item) begin
            cmd_reg <= in_cmd;
            blk_reg <= in_blk;
        end
        if (ctl.scan_start) begin
            scan_ptr_reg <= SCAN_W'(1);
            cnt_reg      <= '0;
        end else if (scan_issue) begin
            scan_ptr_reg <= scan_ptr_reg + 1'b1;
        end
        if (ctl.scan_count && rd_valid_reg && (rd_data_reg == ENTRY_FREE)) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (ctl.take_hit) begin
            ptr_reg <= VAL_W'(rd_blk_reg);
        end
        if (ctl.free_start) begin
            ptr_reg <= VAL_W'(blk_reg);
            cnt_reg <= '0;
        end else if (ctl.free_write) begin
            ptr_reg <= rd_data_reg;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // result value select
    always_comb begin
        case (ctl.res_src)
            SRC_PTR:   res_value = ptr_reg;
            SRC_CNT:   res_value = VAL_W'(cnt_reg);
            SRC_RDATA: res_value = rd_data_reg;
            default:   res_value = '0;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_out) begin
            out_value_reg  <= res_value;
            out_status_reg <= ctl.res_status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

    // status to the controller, from registers and out_ready
    always_comb begin
        sts.cmd       = cmd_reg;
        sts.blk_zero  = (blk_reg == '0);
        sts.blk_over  = (blk_reg > lim_reg);
        sts.lim_zero  = (lim_reg == '0);
        sts.clr_last  = (clr_ptr_reg == ADDR_W'(BLOCK_COUNT - 1));
        sts.scan_hit  = rd_valid_reg && (rd_data_reg == ENTRY_FREE);
        sts.scan_done = (scan_ptr_reg > SCAN_W'(lim_reg)) && !rd_valid_reg;
        sts.walk_end  = (ptr_reg == ENTRY_FREE) || (ptr_reg == ENTRY_END);
        sts.walk_bad  = (ptr_reg > VAL_W'(lim_reg)) || (cnt_reg >= lim_reg);
        sts.out_free  = !out_valid_reg || out_ready;
    end

endmodule

`default_nettype wire

// ----- design/fcba_ctrl.sv -----
`default_nettype none

module fcba_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire fcba_pkg::sts_t sts,
    output fcba_pkg::ctl_t      ctl
);
    import fcba_pkg::*;

    typedef enum logic [11:0] {
        S_INIT       = 12'b0000_0000_0001,
        S_IDLE       = 12'b0000_0000_0010,
        S_DECODE     = 12'b0000_0000_0100,
        S_SCAN_ALLOC = 12'b0000_0000_1000,
        S_SCAN_COUNT = 12'b0000_0001_0000,
        S_ALLOC_END  = 12'b0000_0010_0000,
        S_ALLOC_LINK = 12'b0000_0100_0000,
        S_FREE_RD    = 12'b0000_1000_0000,
        S_FREE_WR    = 12'b0001_0000_0000,
        S_READ_WAIT  = 12'b0010_0000_0000,
        S_CLEAR      = 12'b0100_0000_0000,
        S_DONE       = 12'b1000_0000_0000
    } state_t;

    state_t          state_reg, state_next;
    res_src_t        src_reg, src_next;
    logic [ST_W-1:0] status_reg, status_next;

    // state and pending result code
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_INIT;
            src_reg    <= SRC_ZERO;
            status_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            src_reg    <= src_next;
            status_reg <= status_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        src_next       = src_reg;
        status_next    = status_reg;
        ctl            = '0;
        ctl.res_src    = src_reg;
        ctl.res_status = status_reg;

        unique case (state_reg)
            S_INIT: begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    ctl.take_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE: begin
                src_next    = SRC_ZERO;
                status_next = ST_OK;
                state_next  = S_DONE;
                unique case (sts.cmd)
                    CMD_ALLOC: begin
                        if (!sts.blk_zero && sts.blk_over) begin
                            status_next = ST_BAD;
                        end else if (sts.lim_zero) begin
                            status_next = ST_FULL;
                        end else begin
                            ctl.scan_start = 1'b1;
                            state_next     = S_SCAN_ALLOC;
                        end
                    end
                    CMD_FREE: begin
                        if (sts.blk_zero) begin
                            status_next = ST_OK;
                        end else if (sts.blk_over) begin
                            status_next = ST_BAD;
                        end else begin
                            ctl.free_start = 1'b1;
                            state_next     = S_FREE_RD;
                        end
                    end
                    CMD_READ: begin
                        if (sts.blk_zero || sts.blk_over) begin
                            status_next = ST_BAD;
                        end else begin
                            ctl.read_issue = 1'b1;
                            state_next     = S_READ_WAIT;
                        end
                    end
                    CMD_COUNT: begin
                        ctl.scan_start = 1'b1;
                        state_next     = S_SCAN_COUNT;
                    end
                    CMD_CLEAR: begin
                        ctl.clr_start = 1'b1;
                        state_next    = S_CLEAR;
                    end
                    default: begin
                        status_next = ST_BAD;
                    end
                endcase
            end
            S_SCAN_ALLOC: begin
                ctl.scan_run = 1'b1;
                if (sts.scan_hit) begin
                    ctl.take_hit = 1'b1;
                    state_next   = S_ALLOC_END;
                end else if (sts.scan_done) begin
                    src_next    = SRC_ZERO;
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
            end
            S_SCAN_COUNT: begin
                ctl.scan_run   = 1'b1;
                ctl.scan_count = 1'b1;
                if (sts.scan_done) begin
                    src_next    = SRC_CNT;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
            end
            S_ALLOC_END: begin
                ctl.wr_end  = 1'b1;
                src_next    = SRC_PTR;
                status_next = ST_OK;
                state_next  = sts.blk_zero ? S_DONE : S_ALLOC_LINK;
            end
            S_ALLOC_LINK: begin
                ctl.wr_link = 1'b1;
                state_next  = S_DONE;
            end
            S_FREE_RD: begin
                if (sts.walk_end) begin
                    src_next    = SRC_CNT;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end else if (sts.walk_bad) begin
                    src_next    = SRC_CNT;
                    status_next = ST_BAD;
                    state_next  = S_DONE;
                end else begin
                    ctl.free_read = 1'b1;
                    state_next    = S_FREE_WR;
                end
            end
            S_FREE_WR: begin
                ctl.free_write = 1'b1;
                state_next     = S_FREE_RD;
            end
            S_READ_WAIT: begin
                src_next    = SRC_RDATA;
                status_next = ST_OK;
                state_next  = S_DONE;
            end
            S_CLEAR: begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last) begin
                    src_next    = SRC_ZERO;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/fat_chain_block_allocator.sv -----
`default_nettype none

// channel   | direction | handshake         | payload
// s_axis    | in        | s_tvalid/s_tready | s_tdata: command[2:0], block[14:3]
// m_axis    | out       | m_tvalid/m_tready | m_tdata: value[15:0], status[17:16]
// config    | in        | cfg_we            | cfg_wdata: usable_blocks[11:0]
//
// one command at a time; allocate takes the lowest free block (linking it when a
// block is given), count scans up to the block limit, free clears the chain one
// block at a time, and clear sweeps all BLOCK_COUNT table entries.
// after reset a clearing pass over the whole table runs with s_tready low.
// a finished result waits in the output register while m_tready is low.

module fat_chain_block_allocator #(
    parameter int BLOCK_COUNT = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // command[2:0], block[14:3], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // value[15:0], status[17:16], zero pad
    input  wire logic        cfg_we,
    input  wire logic [11:0] cfg_wdata
);
    import fcba_pkg::*;

    ctl_t             ctl;
    sts_t             sts;
    logic [VAL_W-1:0] out_value;
    logic [ST_W-1:0]  out_status;

    // sequencing
    fcba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // table and registers
    fcba_datapath #(
        .BLOCK_COUNT (BLOCK_COUNT)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .sts        (sts),
        .in_cmd     (s_tdata[CMD_W-1:0]),
        .in_blk     (s_tdata[CMD_W+BLK_W-1:CMD_W]),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (out_value),
        .out_status (out_status)
    );

    // result packing
    assign m_tdata = {6'b0, out_status, out_value};

endmodule

`default_nettype wire

// ----- test/fat_chain_block_allocator_checker.sv -----
`timescale 1ns / 100ps

module fat_chain_block_allocator_checker #(
    parameter int TABLE_SIZE = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,   // command[2:0], block[14:3], zero pad
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,   // value[15:0], status[17:16], zero pad
    input  wire logic        cfg_we,
    input  wire logic [11:0] cfg_wdata,
    output int               fail_count,
    output int               open_count
);
    import fcba_pkg::*;

    localparam int REPORT_MAX   = 10;
    localparam int USABLE_RESET = 4095;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        int unsigned      blk;
        logic [VAL_W-1:0] value;
        logic [ST_W-1:0]  status;
    } table_reply_t;

    // local copy of the allocation table and the block limit register
    logic [VAL_W-1:0] fat_entries [0:TABLE_SIZE-1];
    int unsigned      usable_blocks;
    table_reply_t     pending_replies [$];
    int               mismatches;

    function automatic void log_failure(string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("checker: %s", msg);
    endfunction

    // applies one command to the local table and returns the reply it gives
    function automatic table_reply_t apply_table_command(logic [CMD_W-1:0] cmd,
                                                         int unsigned blk);
        table_reply_t reply;
        int unsigned  lim;
        int unsigned  found;
        int unsigned  cur;
        int unsigned  nxt;
        int unsigned  steps;
        int unsigned  free_total;
        bit           walking;

        reply.cmd    = cmd;
        reply.blk    = blk;
        reply.value  = '0;
        reply.status = ST_OK;
        lim = usable_blocks;
        if (lim > TABLE_SIZE - 1)
            lim = TABLE_SIZE - 1;

        case (cmd)
            CMD_ALLOC: begin
                found = 0;
                if (blk != 0 && blk > lim) begin
                    reply.status = ST_BAD;
                end else begin
                    // descending scan leaves the lowest free block
                    for (int b = lim; b >= 1; b--)
                        if (fat_entries[b] == ENTRY_FREE)
                            found = b;
                    if (found == 0) begin
                        reply.status = ST_FULL;
                    end else begin
                        fat_entries[found] = ENTRY_END;
                        if (blk != 0)
                            fat_entries[blk] = VAL_W'(found);
                        reply.value = VAL_W'(found);
                    end
                end
            end
            CMD_FREE: begin
                if (blk != 0) begin
                    if (blk > lim) begin
                        reply.status = ST_BAD;
                    end else begin
                        // walk the chain, clearing as we go
                        cur     = blk;
                        steps   = 0;
                        walking = 1'b1;
                        while (walking && cur != 0 && cur != ENTRY_END) begin
                            if (cur > lim || steps >= lim) begin
                                reply.status = ST_BAD;
                                walking      = 1'b0;
                            end else begin
                                nxt              = 32'(fat_entries[cur]);
                                fat_entries[cur] = ENTRY_FREE;
                                steps++;
                                cur = nxt;
                            end
                        end
                        reply.value = VAL_W'(steps);
                    end
                end
            end
            CMD_READ: begin
                if (blk == 0 || blk > lim)
                    reply.status = ST_BAD;
                else
                    reply.value = fat_entries[blk];
            end
            CMD_COUNT: begin
                free_total = 0;
                for (int b = 1; b <= lim; b++)
                    if (fat_entries[b] == ENTRY_FREE)
                        free_total++;
                reply.value = VAL_W'(free_total);
            end
            CMD_CLEAR: begin
                foreach (fat_entries[i])
                    fat_entries[i] = ENTRY_FREE;
            end
            default: begin
                reply.status = ST_BAD;
            end
        endcase
        return reply;
    endfunction

    // follow both channels, predict on each command transfer, compare on each result
    always @(posedge aclk) begin : watch_channels
        table_reply_t     want;
        logic [VAL_W-1:0] got_value;
        logic [ST_W-1:0]  got_status;

        if (!aresetn) begin
            foreach (fat_entries[i])
                fat_entries[i] = ENTRY_FREE;
            usable_blocks = USABLE_RESET;
            pending_replies.delete();
            mismatches = 0;
        end else begin
            if (cfg_we)
                usable_blocks = 32'(cfg_wdata);
            if (s_tvalid && s_tready)
                pending_replies.push_back(apply_table_command(s_tdata[CMD_W-1:0],
                                                              32'(s_tdata[CMD_W +: BLK_W])));
            if (m_tvalid && m_tready) begin
                got_value  = m_tdata[VAL_W-1:0];
                got_status = m_tdata[VAL_W +: ST_W];
                if (pending_replies.size() == 0) begin
                    log_failure($sformatf("result with none pending: value %0d status %0d",
                                          got_value, got_status));
                end else begin
                    want = pending_replies.pop_front();
                    if (got_value !== want.value)
                        log_failure($sformatf("cmd %0d block %0d: value expected %0d got %0d",
                                              want.cmd, want.blk, want.value, got_value));
                    if (got_status !== want.status)
                        log_failure($sformatf("cmd %0d block %0d: status expected %0d got %0d",
                                              want.cmd, want.blk, want.status, got_status));
                end
            end
        end
        open_count <= pending_replies.size();
        fail_count <= mismatches;
    end

endmodule

// ----- test/tb_fat_chain_block_allocator.sv -----
`timescale 1ns / 100ps

module tb_fat_chain_block_allocator;
    import fcba_pkg::*;

    localparam int TABLE_SIZE    = 4096;
    localparam int LAST_BLOCK    = 4095;
    localparam int STALL_LIMIT   = 40000;
    localparam int IDLE_PCT      = 32;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 200;
    localparam int PHASES        = 9;
    localparam int STEADY_PHASE  = 4;
    localparam logic [CMD_W-1:0] CMD_HIGHEST = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_we;
    logic [11:0] cfg_wdata;

    int          fail_count;
    int          open_count;
    int          stall_cycles;
    int unsigned cur_usable;
    bit          steady_run;

    // block limit and number of random commands for each phase
    int unsigned usable_plan [PHASES] = '{1, 0, 2, 7, 16, 33, 64, 200, 4095};
    int unsigned length_plan [PHASES] = '{60, 40, 80, 200, 250, 250, 200, 150, 200};

    fat_chain_block_allocator #(
        .BLOCK_COUNT(TABLE_SIZE)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    fat_chain_block_allocator_checker #(
        .TABLE_SIZE(TABLE_SIZE)
    ) i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fail_count(fail_count),
        .open_count(open_count)
    );

    // clock
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic bit take_break();
        return !steady_run && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // result side back-pressure
    always @(negedge aclk) begin
        m_tready <= !take_break();
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // one command transfer, with random gaps in front
    task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [BLK_W-1:0] blk);
        while (take_break()) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, blk, cmd};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // hold off until every pending result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (open_count != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_usable(input int unsigned blocks);
        drain_results();
        cfg_we     <= 1'b1;
        cfg_wdata  <= blocks[BLK_W-1:0];
        cur_usable  = blocks;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        cfg_wdata <= 12'($urandom);
    endtask

    // random command, mostly aimed at blocks inside the current limit
    function automatic void pick_command(output logic [CMD_W-1:0] cmd,
                                         output logic [BLK_W-1:0] blk);
        int unsigned pick;
        int unsigned sub;

        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 9);
        blk  = (cur_usable == 0) ? BLK_W'($urandom) : BLK_W'($urandom_range(1, cur_usable));
        if (pick < 45) begin
            cmd = CMD_ALLOC;
            if (sub < 3)
                blk = '0;
            else if (sub == 9)
                blk = BLK_W'($urandom);
        end else if (pick < 67) begin
            cmd = CMD_FREE;
            if (sub == 0)
                blk = '0;
            else if (sub == 9)
                blk = BLK_W'($urandom);
        end else if (pick < 85) begin
            cmd = CMD_READ;
            if (sub >= 8)
                blk = BLK_W'($urandom);
        end else if (pick < 92) begin
            cmd = CMD_COUNT;
            blk = BLK_W'($urandom);
        end else if (pick < 95) begin
            cmd = CMD_CLEAR;
            blk = BLK_W'($urandom);
        end else begin
            cmd = CMD_W'($urandom_range(CMD_CLEAR + 1, CMD_HIGHEST));
            blk = BLK_W'($urandom);
        end
    endfunction

    initial begin : stimulus
        logic [CMD_W-1:0] rnd_cmd;
        logic [BLK_W-1:0] rnd_blk;

        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        m_tready   = 1'b0;
        cur_usable = LAST_BLOCK;
        steady_run = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // full table: range edges, linking through the last block, unknown commands
        issue_command(CMD_READ, BLK_W'(0));
        issue_command(CMD_READ, BLK_W'(LAST_BLOCK));
        issue_command(CMD_ALLOC, BLK_W'(0));
        issue_command(CMD_ALLOC, BLK_W'(1));
        issue_command(CMD_ALLOC, BLK_W'(LAST_BLOCK));
        issue_command(CMD_READ, BLK_W'(1));
        issue_command(CMD_FREE, BLK_W'(LAST_BLOCK));
        issue_command(CMD_FREE, BLK_W'(0));
        issue_command(CMD_COUNT, BLK_W'(0));
        for (int c = CMD_CLEAR + 1; c <= CMD_HIGHEST; c++)
            issue_command(c[CMD_W-1:0], BLK_W'(LAST_BLOCK));
        issue_command(CMD_CLEAR, BLK_W'(0));

        // four blocks: fill the table, then out of range heads and predecessors
        set_usable(4);
        issue_command(CMD_ALLOC, BLK_W'(0));
        issue_command(CMD_ALLOC, BLK_W'(1));
        issue_command(CMD_ALLOC, BLK_W'(2));
        issue_command(CMD_ALLOC, BLK_W'(3));
        issue_command(CMD_ALLOC, BLK_W'(0));
        issue_command(CMD_ALLOC, BLK_W'(5));
        issue_command(CMD_FREE, BLK_W'(5));
        issue_command(CMD_COUNT, BLK_W'(0));

        // shrunk limit: the chain runs past the limit mid walk
        set_usable(2);
        issue_command(CMD_FREE, BLK_W'(1));

        // one block linked to itself: walk too long
        set_usable(1);
        issue_command(CMD_ALLOC, BLK_W'(1));
        issue_command(CMD_FREE, BLK_W'(1));
        issue_command(CMD_READ, BLK_W'(1));

        // random phases over a range of limits
        for (int p = 0; p < PHASES; p++) begin
            set_usable(usable_plan[p]);
            steady_run = (p == STEADY_PHASE);
            for (int n = 0; n < length_plan[p]; n++) begin
                pick_command(rnd_cmd, rnd_blk);
                issue_command(rnd_cmd, rnd_blk);
                if ($urandom_range(0, 99) == 0)
                    drain_results();
            end
        end
        steady_run = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fail_count == 0 && open_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
design/fcba_pkg.sv
design/fcba_datapath.sv
design/fcba_ctrl.sv
design/fat_chain_block_allocator.sv
test/fat_chain_block_allocator_checker.sv
test/tb_fat_chain_block_allocator.sv
